// ===== rtl/sbf_pkg.sv =====
package sbf_pkg;

    // Default build parameters
    localparam int SPRITE_SIZE_DEF = 8;
    localparam int COLOR_BITS_DEF  = 24;

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int PIX_W   = 4;
    localparam int COLOR_W = 24;
    localparam int FB_W    = 13;
    localparam int COORD_W = 12;
    localparam int CFG_IDX_W = 1;

    // Largest framebuffer extent used for clipping
    localparam logic [FB_W-1:0] COORD_LIMIT = 13'd4096;

    // Register reset values
    localparam logic [FB_W-1:0] FB_WIDTH_RST  = 13'd256;
    localparam logic [FB_W-1:0] FB_HEIGHT_RST = 13'd224;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FLIP_H = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLIP_V = 2'd2;
    localparam logic [CMD_W-1:0] CMD_BLIT   = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACK,
        ST_WALK,
        ST_WAIT,
        ST_FLUSH
    } sbf_state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;    // latch the accepted command, do write or flip
        logic issue;   // read the next sprite pixel of the walk
        logic flush;   // emit the final result of a blit
        logic ack;     // emit the acknowledge of a non-blit command
    } sbf_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic stall;       // evaluation stage cannot move
        logic issue_last;  // walk counter sits on the final pixel
        logic pipe_busy;   // read stage holds a pixel
        logic out_free;    // output register can load this cycle
    } sbf_sts_t;

endpackage

// ===== rtl/sbf_if.sv =====
interface sbf_req_if;
    logic                          valid;
    logic                          ready;
    logic [sbf_pkg::CMD_W-1:0]     cmd;
    logic [sbf_pkg::PIX_W-1:0]     pix_row;
    logic [sbf_pkg::PIX_W-1:0]     pix_col;
    logic [sbf_pkg::COLOR_W-1:0]   pix_color;
    logic                          pix_clear;
    logic signed [sbf_pkg::FB_W-1:0] dest_row;
    logic signed [sbf_pkg::FB_W-1:0] dest_col;

    modport source (output valid, cmd, pix_row, pix_col, pix_color, pix_clear,
                    dest_row, dest_col, input ready);
    modport sink   (input valid, cmd, pix_row, pix_col, pix_color, pix_clear,
                    dest_row, dest_col, output ready);
endinterface

interface sbf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          write_valid;
    logic [sbf_pkg::COORD_W-1:0]   fb_row;
    logic [sbf_pkg::COORD_W-1:0]   fb_col;
    logic [sbf_pkg::COLOR_W-1:0]   out_color;
    logic                          range_error;
    logic                          last;

    modport source (output valid, write_valid, fb_row, fb_col, out_color,
                    range_error, last, input ready);
    modport sink   (input valid, write_valid, fb_row, fb_col, out_color,
                    range_error, last, output ready);
endinterface

interface sbf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sbf_pkg::CFG_IDX_W-1:0]   index;
    logic [sbf_pkg::FB_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sprite_blitter_flip_clip_top.sv =====
// Sprite blitter with mirroring, transparency and framebuffer clipping.
// Channels: req (commands: pixel write, flip horizontal, flip vertical, blit),
// rsp (results: framebuffer writes or acknowledges, last on the final one of
// each command), cfg (framebuffer width at index 0, height at index 1; always
// ready, write only while no command is in flight).
// One command is in work at a time. A pixel write or flip is acknowledged
// from the ACK state once the output register is free. A blit walks the
// sprite one pixel per cycle, unless a stall holds it, through the color
// memory read port, then drains the read stage and flushes. Its
// last write is held back one slot until the walk ends so it can carry last;
// a blit that draws nothing gives one acknowledge.
// A new command is taken as soon as the previous one's final result sits in
// the output register, even if the receiver has not taken it yet.
// When the receiver stalls, the walk pauses once a second write is waiting;
// nothing is dropped.
// Reset marks every sprite pixel transparent, clears both mirror flags and
// sets the framebuffer size to 256 by 224; no clearing pass is needed.
module sprite_blitter_flip_clip_top #(
    parameter int SPRITE_SIZE = sbf_pkg::SPRITE_SIZE_DEF,
    parameter int COLOR_BITS  = sbf_pkg::COLOR_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sbf_req_if.sink   req,
    sbf_rsp_if.source rsp,
    sbf_cfg_if.sink   cfg
);

    sbf_pkg::sbf_ctl_t ctl;
    sbf_pkg::sbf_sts_t sts;

    // Configuration channel never stalls
    assign cfg.ready = 1'b1;

    // Command sequencer
    sbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_cmd   (req.cmd),
        .in_ready (req.ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Sprite store, walk pipeline and result register
    sbf_datapath #(
        .SPRITE_SIZE (SPRITE_SIZE),
        .COLOR_BITS  (COLOR_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (sts),
        .in_cmd          (req.cmd),
        .in_pix_row      (req.pix_row),
        .in_pix_col      (req.pix_col),
        .in_pix_color    (req.pix_color),
        .in_pix_clear    (req.pix_clear),
        .in_dest_row     (req.dest_row),
        .in_dest_col     (req.dest_col),
        .cfg_we          (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .out_ready       (rsp.ready),
        .out_valid       (rsp.valid),
        .out_write_valid (rsp.write_valid),
        .out_fb_row      (rsp.fb_row),
        .out_fb_col      (rsp.fb_col),
        .out_color       (rsp.out_color),
        .out_range_error (rsp.range_error),
        .out_last        (rsp.last)
    );

endmodule

// ===== rtl/sbf_ctrl.sv =====
module sbf_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [sbf_pkg::CMD_W-1:0]  in_cmd,
    output logic                       in_ready,
    input  sbf_pkg::sbf_sts_t          sts,
    output sbf_pkg::sbf_ctl_t          ctl
);

    sbf_pkg::sbf_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            sbf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.take = 1'b1;
                    if (in_cmd == sbf_pkg::CMD_BLIT)
                    begin
                        state_next = sbf_pkg::ST_WALK;
                    end
                    else
                    begin
                        state_next = sbf_pkg::ST_ACK;
                    end
                end
            end
            sbf_pkg::ST_ACK:
            begin
                if (sts.out_free)
                begin
                    ctl.ack    = 1'b1;
                    state_next = sbf_pkg::ST_IDLE;
                end
            end
            sbf_pkg::ST_WALK:
            begin
                // one pixel read per cycle unless evaluation is blocked
                if (!sts.stall)
                begin
                    ctl.issue = 1'b1;
                    if (sts.issue_last)
                    begin
                        state_next = sbf_pkg::ST_WAIT;
                    end
                end
            end
            sbf_pkg::ST_WAIT:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = sbf_pkg::ST_FLUSH;
                end
            end
            sbf_pkg::ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    ctl.flush  = 1'b1;
                    state_next = sbf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sbf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sbf_datapath.sv =====
module sbf_datapath #(
    parameter int SPRITE_SIZE = sbf_pkg::SPRITE_SIZE_DEF,
    parameter int COLOR_BITS  = sbf_pkg::COLOR_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sbf_pkg::sbf_ctl_t                   ctl,
    output sbf_pkg::sbf_sts_t                   sts,
    // accepted command fields
    input  logic [sbf_pkg::CMD_W-1:0]           in_cmd,
    input  logic [sbf_pkg::PIX_W-1:0]           in_pix_row,
    input  logic [sbf_pkg::PIX_W-1:0]           in_pix_col,
    input  logic [sbf_pkg::COLOR_W-1:0]         in_pix_color,
    input  logic                                in_pix_clear,
    input  logic signed [sbf_pkg::FB_W-1:0]     in_dest_row,
    input  logic signed [sbf_pkg::FB_W-1:0]     in_dest_col,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [sbf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sbf_pkg::FB_W-1:0]            cfg_data,
    // result register
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic                                out_write_valid,
    output logic [sbf_pkg::COORD_W-1:0]         out_fb_row,
    output logic [sbf_pkg::COORD_W-1:0]         out_fb_col,
    output logic [sbf_pkg::COLOR_W-1:0]         out_color,
    output logic                                out_range_error,
    output logic                                out_last
);

    localparam int PIX_COUNT = SPRITE_SIZE * SPRITE_SIZE;
    localparam int RW = (SPRITE_SIZE > 1) ? $clog2(SPRITE_SIZE) : 1;
    localparam int AW = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;
    localparam int CW_KEEP = (COLOR_BITS < sbf_pkg::COLOR_W) ? COLOR_BITS : sbf_pkg::COLOR_W;
    localparam int TW = sbf_pkg::FB_W + 1;
    localparam logic [RW-1:0] IDX_MAX = RW'(SPRITE_SIZE - 1);

    // Mirror flags and framebuffer size
    logic                     mirror_h_reg;
    logic                     mirror_v_reg;
    logic [sbf_pkg::FB_W-1:0] fb_width_reg;
    logic [sbf_pkg::FB_W-1:0] fb_height_reg;

    // Latched command state
    logic                          range_err_reg;
    logic signed [sbf_pkg::FB_W-1:0] orow_reg;
    logic signed [sbf_pkg::FB_W-1:0] ocol_reg;

    // Sprite storage: color in memory, opaque marks in flops cleared at reset
    logic [COLOR_BITS-1:0] color_mem [PIX_COUNT];
    logic [PIX_COUNT-1:0]  opaque_reg;

    // Walk counters and read stage
    logic [RW-1:0]          r_cnt_reg;
    logic [RW-1:0]          c_cnt_reg;
    logic                   s1_valid_reg;
    logic [RW-1:0]          s1_r_reg;
    logic [RW-1:0]          s1_c_reg;
    logic [COLOR_BITS-1:0]  rd_color_reg;
    logic                   rd_opaque_reg;

    // One-deep hold of the newest blit write, so the final one gets last
    logic                          pend_valid_reg, pend_valid_next;
    logic [sbf_pkg::COORD_W-1:0]   pend_row_reg, pend_row_next;
    logic [sbf_pkg::COORD_W-1:0]   pend_col_reg, pend_col_next;
    logic [sbf_pkg::COLOR_W-1:0]   pend_color_reg, pend_color_next;

    // Output register
    logic                          out_valid_reg, out_valid_next;
    logic                          out_wv_reg, out_wv_next;
    logic [sbf_pkg::COORD_W-1:0]   out_row_reg, out_row_next;
    logic [sbf_pkg::COORD_W-1:0]   out_col_reg, out_col_next;
    logic [sbf_pkg::COLOR_W-1:0]   out_color_reg, out_color_next;
    logic                          out_err_reg, out_err_next;
    logic                          out_last_reg, out_last_next;

    logic                   wr_in_range;
    logic [RW-1:0]          wr_r;
    logic [RW-1:0]          wr_c;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic [COLOR_BITS-1:0]  wr_color;
    logic [sbf_pkg::FB_W-1:0] hlim;
    logic [sbf_pkg::FB_W-1:0] wlim;
    logic [TW-1:0]          tr;
    logic [TW-1:0]          tc;
    logic                   hit;
    logic                   out_free;
    logic                   stall;
    logic                   eval_go;

    // Logical to stored address through the mirror flags
    function automatic logic [AW-1:0] map_addr(input logic [RW-1:0] r,
                                               input logic [RW-1:0] c,
                                               input logic mv,
                                               input logic mh);
        logic [RW-1:0] pr;
        logic [RW-1:0] pc;
        pr = mv ? (IDX_MAX - r) : r;
        pc = mh ? (IDX_MAX - c) : c;
        return AW'(int'(pr) * SPRITE_SIZE + int'(pc));
    endfunction

    // Pixel write decode
    assign wr_in_range = (int'(in_pix_row) < SPRITE_SIZE) && (int'(in_pix_col) < SPRITE_SIZE);
    assign wr_r        = in_pix_row[RW-1:0];
    assign wr_c        = in_pix_col[RW-1:0];
    assign wr_addr     = map_addr(wr_r, wr_c, mirror_v_reg, mirror_h_reg);
    assign wr_color    = COLOR_BITS'(in_pix_color[CW_KEEP-1:0]);
    assign rd_addr     = map_addr(r_cnt_reg, c_cnt_reg, mirror_v_reg, mirror_h_reg);

    // Configuration and mirror flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_width_reg  <= sbf_pkg::FB_WIDTH_RST;
            fb_height_reg <= sbf_pkg::FB_HEIGHT_RST;
            mirror_h_reg  <= 1'b0;
            mirror_v_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == sbf_pkg::REG_FB_WIDTH))
            begin
                fb_width_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == sbf_pkg::REG_FB_HEIGHT))
            begin
                fb_height_reg <= cfg_data;
            end
            if (ctl.take && (in_cmd == sbf_pkg::CMD_FLIP_H))
            begin
                mirror_h_reg <= ~mirror_h_reg;
            end
            if (ctl.take && (in_cmd == sbf_pkg::CMD_FLIP_V))
            begin
                mirror_v_reg <= ~mirror_v_reg;
            end
        end
    end

    // Latch command fields
    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            range_err_reg <= (in_cmd == sbf_pkg::CMD_WRITE) && !wr_in_range;
            orow_reg      <= in_dest_row;
            ocol_reg      <= in_dest_col;
        end
    end

    // Color memory: write on pixel command, registered read during walk
    always_ff @(posedge clk)
    begin
        if (ctl.take && (in_cmd == sbf_pkg::CMD_WRITE) && wr_in_range)
        begin
            color_mem[wr_addr] <= wr_color;
        end
        if (ctl.issue)
        begin
            rd_color_reg <= color_mem[rd_addr];
            s1_r_reg     <= r_cnt_reg;
            s1_c_reg     <= c_cnt_reg;
        end
    end

    // Opaque marks, walk counters, read stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opaque_reg    <= '0;
            rd_opaque_reg <= 1'b0;
            r_cnt_reg     <= '0;
            c_cnt_reg     <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.take && (in_cmd == sbf_pkg::CMD_WRITE) && wr_in_range)
            begin
                opaque_reg[wr_addr] <= ~in_pix_clear;
            end
            if (ctl.take)
            begin
                r_cnt_reg <= '0;
                c_cnt_reg <= '0;
            end
            else if (ctl.issue)
            begin
                rd_opaque_reg <= opaque_reg[rd_addr];
                if (c_cnt_reg == IDX_MAX)
                begin
                    c_cnt_reg <= '0;
                    r_cnt_reg <= r_cnt_reg + 1'b1;
                end
                else
                begin
                    c_cnt_reg <= c_cnt_reg + 1'b1;
                end
            end
            if (!stall)
            begin
                s1_valid_reg <= ctl.issue;
            end
        end
    end

    // Clip test on the read stage
    assign hlim = (fb_height_reg > sbf_pkg::COORD_LIMIT) ? sbf_pkg::COORD_LIMIT : fb_height_reg;
    assign wlim = (fb_width_reg > sbf_pkg::COORD_LIMIT) ? sbf_pkg::COORD_LIMIT : fb_width_reg;
    assign tr   = {orow_reg[sbf_pkg::FB_W-1], orow_reg} + TW'(s1_r_reg);
    assign tc   = {ocol_reg[sbf_pkg::FB_W-1], ocol_reg} + TW'(s1_c_reg);
    assign hit  = s1_valid_reg && rd_opaque_reg
                  && !tr[TW-1] && (tr[TW-2:0] < hlim)
                  && !tc[TW-1] && (tc[TW-2:0] < wlim);

    assign out_free = !out_valid_reg || out_ready;
    assign stall    = hit && pend_valid_reg && !out_free;
    assign eval_go  = s1_valid_reg && !stall;

    // Hold stage and output register next values
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_row_next   = pend_row_reg;
        pend_col_next   = pend_col_reg;
        pend_color_next = pend_color_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        out_wv_next     = out_wv_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_color_next  = out_color_reg;
        out_err_next    = out_err_reg;
        out_last_next   = out_last_reg;

        if (eval_go && hit)
        begin
            // previous write moves on, new one is held
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_wv_next    = 1'b1;
                out_row_next   = pend_row_reg;
                out_col_next   = pend_col_reg;
                out_color_next = pend_color_reg;
                out_err_next   = 1'b0;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_row_next   = tr[sbf_pkg::COORD_W-1:0];
            pend_col_next   = tc[sbf_pkg::COORD_W-1:0];
            pend_color_next = sbf_pkg::COLOR_W'(rd_color_reg[CW_KEEP-1:0]);
        end
        else if (ctl.flush)
        begin
            // final blit result: held write, or acknowledge if none drawn
            out_valid_next  = 1'b1;
            out_wv_next     = pend_valid_reg;
            out_row_next    = pend_valid_reg ? pend_row_reg : '0;
            out_col_next    = pend_valid_reg ? pend_col_reg : '0;
            out_color_next  = pend_valid_reg ? pend_color_reg : '0;
            out_err_next    = 1'b0;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
        else if (ctl.ack)
        begin
            out_valid_next = 1'b1;
            out_wv_next    = 1'b0;
            out_row_next   = '0;
            out_col_next   = '0;
            out_color_next = '0;
            out_err_next   = range_err_reg;
            out_last_next  = 1'b1;
        end
    end

    // Control flops of hold stage and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload flops
    always_ff @(posedge clk)
    begin
        pend_row_reg   <= pend_row_next;
        pend_col_reg   <= pend_col_next;
        pend_color_reg <= pend_color_next;
        out_wv_reg     <= out_wv_next;
        out_row_reg    <= out_row_next;
        out_col_reg    <= out_col_next;
        out_color_reg  <= out_color_next;
        out_err_reg    <= out_err_next;
        out_last_reg   <= out_last_next;
    end

    // Status to controller
    assign sts.stall      = stall;
    assign sts.issue_last = (r_cnt_reg == IDX_MAX) && (c_cnt_reg == IDX_MAX);
    assign sts.pipe_busy  = s1_valid_reg;
    assign sts.out_free   = out_free;

    assign out_valid       = out_valid_reg;
    assign out_write_valid = out_wv_reg;
    assign out_fb_row      = out_row_reg;
    assign out_fb_col      = out_col_reg;
    assign out_color       = out_color_reg;
    assign out_range_error = out_err_reg;
    assign out_last        = out_last_reg;

endmodule
